/* design/spes_pkg.sv */
// Shared types and constants for the strict-priority event stacks.
// Used by strict_priority_event_stacks; depends on nothing else.
package spes_pkg;

    // Default geometry
    localparam int NUM_LEVELS_DEF  = 4;
    localparam int LEVEL_DEPTH_DEF = 16;

    // Field widths fixed by the beat layout
    localparam int PRIO_W       = 3;
    localparam int HANDLE_W     = 32;
    localparam int IN_TDATA_W   = 40;  // prio + handle = 35 bits, padded to bytes
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 40;  // handle + prio = 35 bits, padded to bytes
    localparam int OUT_TUSER_W  = 2;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY        = 2'd1,
        ST_BAD_PRIORITY = 2'd2,
        ST_FULL         = 2'd3
    } status_t;

endpackage

/* design/strict_priority_event_stacks.sv */
// Strict-priority event stacks: one LIFO of event handles per priority level.
// An accepted input beat goes through the input and result register stages to m_.
// Throughput: one beat per cycle; the only stall is backpressure on the m_ side.
// The level fill counters and the single-port-write handle memory set the pace.
// Reset (rst_n low, asynchronous) empties every level; the handle memory is not
// cleared, since only entries below a level's fill count are ever read.
module strict_priority_event_stacks #(
    parameter int NUM_LEVELS  = spes_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = spes_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spes_pkg::IN_TDATA_W-1:0]  s_tdata,   // [2:0] priority_req, [34:3] event_handle
    input  logic [spes_pkg::IN_TUSER_W-1:0]  s_tuser,   // [0] cmd
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spes_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] popped_handle, [34:32] popped_priority
    output logic [spes_pkg::OUT_TUSER_W-1:0] m_tuser    // [1:0] status
);

    localparam int TOTAL   = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int PRIO_W  = spes_pkg::PRIO_W;
    localparam int HANDLE_W = spes_pkg::HANDLE_W;
    localparam int PAD_W   = spes_pkg::OUT_TDATA_W - HANDLE_W - PRIO_W;

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [PRIO_W-1:0]   s1_prio_reg;
    logic [HANDLE_W-1:0] s1_handle_reg;

    // Result register stage
    logic                out_valid_reg;
    spes_pkg::status_t   out_status_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic                out_pop_ok_reg;
    logic [HANDLE_W-1:0] rd_data_reg;

    // Per-level fill counts
    logic [FILL_W-1:0]   fill_reg [NUM_LEVELS];

    // Handle memory, laid out level by level
    logic [HANDLE_W-1:0] store_mem [TOTAL];

    logic                out_free;
    logic                advance;

    // Result stage can take a beat when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Payload: load on every accepted beat, no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_cmd_reg    <= s_tuser[0];
            s1_prio_reg   <= s_tdata[PRIO_W-1:0];
            s1_handle_reg <= s_tdata[PRIO_W +: HANDLE_W];
        end
    end

    // ------------------------------------------------------------------
    // Decision logic on the registered command
    // ------------------------------------------------------------------
    logic                prio_ok;
    logic [LVL_W-1:0]    push_lvl;
    logic [FILL_W-1:0]   push_fill;
    logic                push_full;
    logic                pop_found;
    logic [LVL_W-1:0]    pop_lvl;
    logic [FILL_W-1:0]   pop_fill;
    logic                is_pop;
    logic                push_do;
    logic                pop_do;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    spes_pkg::status_t   status_next;
    logic [PRIO_W-1:0]   prio_next;

    assign is_pop  = (s1_cmd_reg == spes_pkg::CMD_POP);
    assign prio_ok = ({1'b0, s1_prio_reg} < (PRIO_W + 1)'(NUM_LEVELS));
    // Steer an out-of-range priority to level zero; the push is refused anyway.
    assign push_lvl  = prio_ok ? s1_prio_reg[LVL_W-1:0] : '0;
    assign push_fill = fill_reg[push_lvl];
    assign push_full = (push_fill == FILL_W'(LEVEL_DEPTH));

    // Priority pick: the highest non-empty level wins.
    always_comb
    begin
        pop_found = 1'b0;
        pop_lvl   = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (fill_reg[l] != '0)
            begin
                pop_found = 1'b1;
                pop_lvl   = LVL_W'(l);
            end
        end
    end

    assign pop_fill = fill_reg[pop_lvl];

    assign push_do = advance && !is_pop && prio_ok && !push_full;
    assign pop_do  = advance && is_pop && pop_found;

    assign wr_addr = ADDR_W'(push_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(push_fill);
    assign rd_addr = ADDR_W'(pop_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pop_fill - FILL_W'(1));

    always_comb
    begin
        status_next = spes_pkg::ST_OK;
        prio_next   = '0;
        if (is_pop)
        begin
            if (pop_found)
            begin
                prio_next = PRIO_W'(pop_lvl);
            end
            else
            begin
                status_next = spes_pkg::ST_EMPTY;
            end
        end
        else if (!prio_ok)
        begin
            status_next = spes_pkg::ST_BAD_PRIORITY;
        end
        else if (push_full)
        begin
            status_next = spes_pkg::ST_FULL;
        end
    end

    // Advance the fill counts: push grows one level, pop shrinks one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                fill_reg[l] <= '0;
            end
        end
        else
        begin
            if (push_do)
            begin
                fill_reg[push_lvl] <= push_fill + FILL_W'(1);
            end
            if (pop_do)
            begin
                fill_reg[pop_lvl] <= pop_fill - FILL_W'(1);
            end
        end
    end

    // Handle memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (push_do)
        begin
            store_mem[wr_addr] <= s1_handle_reg;
        end
        if (pop_do)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_prio_reg   <= prio_next;
            out_pop_ok_reg <= is_pop && pop_found;
        end
    end

    // Hold the handle at zero unless the beat is a successful pop.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_prio_reg,
                       (out_pop_ok_reg ? rd_data_reg : {HANDLE_W{1'b0}})};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Refused or empty results carry no handle and no level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != spes_pkg::ST_OK)) |-> (m_tdata[HANDLE_W+PRIO_W-1:0] == '0))
    else $error("non-ok result carries payload");

    // An empty result stage never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with empty result stage");

    // A reported level is always a real level.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[HANDLE_W +: PRIO_W]} < (PRIO_W + 1)'(NUM_LEVELS)))
    else $error("popped level out of range");

    // A push never lands on a full level.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_do |=> (fill_reg[$past(push_lvl)] <= FILL_W'(LEVEL_DEPTH)))
    else $error("level fill overflow");

endmodule
